>>> sv/cpba_pkg.sv
`default_nettype none
package cpba_pkg;

  localparam int MAX_POOL_PAGES_DEF = 32768;

  // page map word geometry
  localparam int MAP_WORD_BITS = 32;
  localparam int BIT_IDX_W     = 5;
  localparam int RUN_W         = 17;
  localparam int PAGE_SHIFT    = 12;

  localparam logic [1:0] ACT_ALLOC = 2'd0;
  localparam logic [1:0] ACT_FREE  = 2'd1;
  localparam logic [1:0] ACT_INIT  = 2'd2;

  localparam int CFG_ADDR_W = 4;

  typedef struct packed {
    logic                 found;
    logic [BIT_IDX_W-1:0] pos;
    logic [RUN_W-1:0]     run_out;
  } scan_res_t;

endpackage
`default_nettype wire

>>> sv/cpba_map_ram.sv
`default_nettype none
module cpba_map_ram
  import cpba_pkg::*;
#(
  parameter int WORDS = MAX_POOL_PAGES_DEF / MAP_WORD_BITS,
  parameter int AW    = $clog2(MAX_POOL_PAGES_DEF / MAP_WORD_BITS)
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [AW-1:0]            waddr,
  input  wire logic [MAP_WORD_BITS-1:0] wdata,
  input  wire logic [AW-1:0]            raddr,
  output logic      [MAP_WORD_BITS-1:0] rdata
);

  logic [MAP_WORD_BITS-1:0] mem [WORDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> sv/cpba_word_scan.sv
`default_nettype none
module cpba_word_scan
  import cpba_pkg::*;
(
  input  wire logic [MAP_WORD_BITS-1:0] free_bits,
  input  wire logic [RUN_W-1:0]         run_in,
  input  wire logic [15:0]              need,
  output scan_res_t                     res
);

  logic [RUN_W-1:0] run_a [MAP_WORD_BITS];

  // run length ending at each bit, from the nearest used bit at or below it
  always_comb begin
    logic                 lu_v;
    logic [BIT_IDX_W-1:0] lu;
    for (int i = 0; i < MAP_WORD_BITS; i++) begin
      lu_v = 1'b0;
      lu   = '0;
      for (int j = 0; j < MAP_WORD_BITS; j++) begin
        if (j <= i && !free_bits[j]) begin
          lu_v = 1'b1;
          lu   = BIT_IDX_W'(j);
        end
      end
      if (lu_v) begin
        run_a[i] = RUN_W'(i) - RUN_W'(lu);
      end else begin
        run_a[i] = run_in + RUN_W'(i + 1);
      end
    end
  end

  always_comb begin
    res = '0;
    for (int i = MAP_WORD_BITS - 1; i >= 0; i--) begin
      if (run_a[i] == {1'b0, need}) begin
        res.found = 1'b1;
        res.pos   = BIT_IDX_W'(i);
      end
    end
    res.run_out = run_a[MAP_WORD_BITS-1];
  end

endmodule
`default_nettype wire

>>> sv/contiguous_page_bitmap_allocator.sv
// Channel   Dir  Handshake           Beat payload
// in_*      in   in_valid/in_ready   action, pages_requested, address
// out_*     out  out_valid/out_ready status, alloc_address, free/used page counts
// APB       in   psel/penable/pready pool_base (0x0), page_count (0x8)
//
// The page map sits in one single-port-write RAM of 32-bit words (one bit per page).
// Allocate: scans map words in order (up to MAX_POOL_PAGES/32), then reads and
// rewrites each word touched by the run. Free: range checks, then the same read and rewrite.
// Initialize: clears every map word, one a cycle.
// After reset the same clearing pass runs, in_ready low.
// One item at a time; a finished beat waits in the output register while the
// next item is taken, and the block stalls in its final state until that beat leaves.
// MAX_POOL_PAGES must be a power of two, at least 64.
`default_nettype none
module contiguous_page_bitmap_allocator
  import cpba_pkg::*;
#(
  parameter int MAX_POOL_PAGES = MAX_POOL_PAGES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [1:0]            in_action,
  input  wire logic [15:0]           in_pages_requested,
  input  wire logic [47:0]           in_address,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       out_status,
  output logic [47:0]                out_alloc_address,
  output logic [15:0]                out_free_page_count,
  output logic [15:0]                out_used_page_count,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [63:0]           pwdata,
  output logic [63:0]                prdata,
  output logic                       pready
);

  localparam int PIW   = $clog2(MAX_POOL_PAGES);
  localparam int WORDS = MAX_POOL_PAGES / MAP_WORD_BITS;
  localparam int WAW   = PIW - BIT_IDX_W;
  localparam int TW    = PIW + 1;
  localparam int EW    = (TW > RUN_W) ? TW : RUN_W;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_CHK1 = 3'd3;
  localparam logic [2:0] S_CHK2 = 3'd4;
  localparam logic [2:0] S_RD   = 3'd5;
  localparam logic [2:0] S_WR   = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0]       state_r;
  logic [46:0]      base_r;
  logic [15:0]      pcount_r;
  logic [15:0]      fc_r;
  logic [15:0]      n_r;
  logic [47:0]      addr_r;
  logic [47:0]      diff_r;
  logic             ok_r;
  logic             init_r;
  logic             set_r;
  logic             alloc_ok_r;
  logic             status_r;
  logic [RUN_W-1:0] run_r;
  logic [WAW-1:0]   rd_w_r;
  logic [WAW-1:0]   ev_w_r;
  logic             ev_v_r;
  logic [WAW-1:0]   w_r;
  logic [WAW-1:0]   clr_w_r;
  logic [PIW-1:0]   lo_r;
  logic [PIW-1:0]   hi_r;
  logic             out_valid_r;
  logic             out_status_r;
  logic [47:0]      out_addr_r;
  logic [15:0]      out_free_r;
  logic [15:0]      out_used_r;

  // pool size, clamped to the map depth
  logic [EW-1:0] pc_ext;
  logic [EW-1:0] total;
  logic [EW-1:0] total_m1;
  logic [WAW-1:0] last_w;
  assign pc_ext   = EW'(pcount_r);
  assign total    = (pc_ext > EW'(MAX_POOL_PAGES)) ? EW'(MAX_POOL_PAGES) : pc_ext;
  assign total_m1 = total - EW'(1);
  assign last_w   = total_m1[PIW-1:BIT_IDX_W];

  // ---------------- map RAM ----------------
  logic                     ram_we;
  logic [WAW-1:0]           ram_waddr;
  logic [MAP_WORD_BITS-1:0] ram_wdata;
  logic [WAW-1:0]           ram_raddr;
  logic [MAP_WORD_BITS-1:0] ram_rdata;

  cpba_map_ram #(.WORDS(WORDS), .AW(WAW)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ---------------- scan of one word ----------------
  // bits past the pool end count as used
  logic [MAP_WORD_BITS-1:0] vmask;
  logic [MAP_WORD_BITS-1:0] free_bits;
  scan_res_t                sres;
  always_comb begin
    for (int i = 0; i < MAP_WORD_BITS; i++) begin
      vmask[i] = (ev_w_r != last_w) || (BIT_IDX_W'(i) <= total_m1[BIT_IDX_W-1:0]);
    end
  end
  assign free_bits = ~ram_rdata & vmask;

  cpba_word_scan u_scan (
    .free_bits (free_bits),
    .run_in    (run_r),
    .need      (n_r),
    .res       (sres)
  );

  logic [PIW-1:0] end_pg;
  logic [EW-1:0]  start_e;
  logic [PIW-1:0] start_pg;
  assign end_pg   = {ev_w_r, sres.pos};
  assign start_e  = EW'(end_pg) + EW'(1) - EW'(n_r);
  assign start_pg = start_e[PIW-1:0];

  // ---------------- range read-modify-write ----------------
  logic [WAW-1:0]           lo_w;
  logic [WAW-1:0]           hi_w;
  logic [BIT_IDX_W-1:0]     lb;
  logic [BIT_IDX_W-1:0]     hb;
  logic [MAP_WORD_BITS-1:0] rmask;
  logic [BIT_IDX_W:0]       pop;
  logic [16:0]              fc_sum;
  assign lo_w = lo_r[PIW-1:BIT_IDX_W];
  assign hi_w = hi_r[PIW-1:BIT_IDX_W];
  assign lb   = (w_r == lo_w) ? lo_r[BIT_IDX_W-1:0] : '0;
  assign hb   = (w_r == hi_w) ? hi_r[BIT_IDX_W-1:0] : '1;

  always_comb begin
    pop = '0;
    for (int i = 0; i < MAP_WORD_BITS; i++) begin
      rmask[i] = (BIT_IDX_W'(i) >= lb) && (BIT_IDX_W'(i) <= hb);
      pop      = pop + (BIT_IDX_W+1)'(ram_rdata[i] & rmask[i]);
    end
  end
  // free count saturates at its top
  assign fc_sum = 17'(fc_r) + 17'(pop);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_w_r;
    ram_wdata = '0;
    ram_raddr = rd_w_r;
    unique case (state_r)
      S_CLR: ram_we = 1'b1;
      S_RD:  ram_raddr = w_r;
      S_WR: begin
        ram_we    = 1'b1;
        ram_waddr = w_r;
        ram_wdata = set_r ? (ram_rdata | rmask) : (ram_rdata & ~rmask);
      end
      default: ;
    endcase
  end

  // free range checks
  logic [36:0] fr_start;
  logic [36:0] fr_end;
  logic        fr_ok;
  assign fr_start = {1'b0, diff_r[47:PAGE_SHIFT]};
  assign fr_end   = fr_start + 37'(n_r);
  assign fr_ok    = ok_r && (fr_start < 37'(total)) && (fr_end <= 37'(total));

  // ---------------- sequencer ----------------
  assign in_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_w_r     <= '0;
      init_r      <= 1'b0;
      fc_r        <= '0;
      ev_v_r      <= 1'b0;
    end else begin
      unique case (state_r)
        S_CLR: begin
          clr_w_r <= clr_w_r + WAW'(1);
          if (clr_w_r == WAW'(WORDS - 1)) begin
            state_r <= init_r ? S_DONE : S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            n_r        <= in_pages_requested;
            addr_r     <= in_address;
            alloc_ok_r <= 1'b0;
            status_r   <= 1'b1;
            case (in_action)
              ACT_ALLOC: begin
                if (in_pages_requested == '0 || in_pages_requested > fc_r ||
                    total == '0) begin
                  state_r <= S_DONE;
                end else begin
                  state_r <= S_SCAN;
                  rd_w_r  <= '0;
                  ev_v_r  <= 1'b0;
                  run_r   <= '0;
                end
              end
              ACT_FREE: state_r <= S_CHK1;
              ACT_INIT: begin
                fc_r     <= 16'(total);
                clr_w_r  <= '0;
                init_r   <= 1'b1;
                status_r <= 1'b0;
                state_r  <= S_CLR;
              end
              default: state_r <= S_DONE;
            endcase
          end
        end
        S_SCAN: begin
          // read of the next word overlaps evaluation of the current one
          rd_w_r <= rd_w_r + WAW'(1);
          ev_w_r <= rd_w_r;
          ev_v_r <= 1'b1;
          if (ev_v_r) begin
            if (sres.found) begin
              lo_r       <= start_pg;
              hi_r       <= end_pg;
              w_r        <= start_pg[PIW-1:BIT_IDX_W];
              set_r      <= 1'b1;
              fc_r       <= fc_r - n_r;
              alloc_ok_r <= 1'b1;
              status_r   <= 1'b0;
              state_r    <= S_RD;
            end else if (ev_w_r == last_w) begin
              state_r <= S_DONE;
            end else begin
              run_r <= sres.run_out;
            end
          end
        end
        S_CHK1: begin
          diff_r  <= addr_r - {1'b0, base_r};
          ok_r    <= (addr_r != '0) && (n_r != '0) && (addr_r >= {1'b0, base_r});
          state_r <= S_CHK2;
        end
        S_CHK2: begin
          if (fr_ok) begin
            lo_r     <= fr_start[PIW-1:0];
            hi_r     <= PIW'(fr_end - 37'd1);
            w_r      <= fr_start[PIW-1:BIT_IDX_W];
            set_r    <= 1'b0;
            status_r <= 1'b0;
            state_r  <= S_RD;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_RD: state_r <= S_WR;
        S_WR: begin
          if (!set_r) begin
            fc_r <= fc_sum[16] ? 16'hFFFF : fc_sum[15:0];
          end
          if (w_r == hi_w) begin
            state_r <= S_DONE;
          end else begin
            w_r     <= w_r + WAW'(1);
            state_r <= S_RD;
          end
        end
        S_DONE: begin
          init_r <= 1'b0;
          if (!out_valid_r || out_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // result beat valid: loads when the sequencer finishes, drops when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result beat payload
  always_ff @(posedge clk) begin
    if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
      out_status_r <= status_r;
      out_addr_r   <= alloc_ok_r ?
                      ({1'b0, base_r} + (48'(lo_r) << PAGE_SHIFT)) : '0;
      out_free_r   <= fc_r;
      out_used_r   <= (EW'(fc_r) > total) ? '0 : 16'(total - EW'(fc_r));
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_alloc_address   = out_addr_r;
  assign out_free_page_count = out_free_r;
  assign out_used_page_count = out_used_r;

  // ---------------- configuration ----------------
  // register select on paddr[3]: 0x0 pool_base, 0x8 page_count
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= '0;
      pcount_r <= '0;
    end else if (psel && penable && pwrite) begin
      if (paddr[3]) begin
        pcount_r <= pwdata[15:0];
      end else begin
        base_r <= pwdata[46:0];
      end
    end
  end

  assign prdata = paddr[3] ? {48'd0, pcount_r} : {17'd0, base_r};

`ifndef SYNTH
  a_ram_we_state: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_CLR || state_r == S_WR))
    else $error("map written outside clear or update");

  a_free_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WR && !set_r) |=> (fc_r >= $past(fc_r)))
    else $error("free count dropped during free");

  a_scan_args: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (total != '0 && n_r != '0 && n_r <= fc_r))
    else $error("scan entered with bad request");
`endif

endmodule
`default_nettype wire

>>> dv/contiguous_page_bitmap_allocator_tb.sv
// Checks the first-fit page allocator end to end.
// A behavioral copy of the page map and free counter predicts each result
// beat at the moment its request beat is accepted. A monitor on the result
// channel pops the oldest prediction and compares every field. Both
// channels idle at random. Pool registers change over the APB port only
// while nothing is in flight.
`default_nettype none
module contiguous_page_bitmap_allocator_tb;
  import cpba_pkg::*;

  localparam int POOL_MAX = 32768;
  localparam logic [1:0] ACT_UNKNOWN = 2'd3;
  // 47-bit register forces 8-byte spacing
  localparam logic [CFG_ADDR_W-1:0] REG_POOL_BASE  = 4'h0;
  localparam logic [CFG_ADDR_W-1:0] REG_PAGE_COUNT = 4'h8;
  localparam longint unsigned PAGE_BYTES = 64'd4096;

  typedef struct {
    bit        status;
    bit [47:0] alloc_addr;
    bit [15:0] free_cnt;
    bit [15:0] used_pages;
  } alloc_result_t;

  // a run handed out by the allocator, kept so frees can target it
  typedef struct {
    bit [47:0]   addr;
    int unsigned pages;
  } page_run_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [1:0]            in_action;
  logic [15:0]           in_pages_requested;
  logic [47:0]           in_address;
  logic                  out_valid;
  logic                  out_ready;
  logic                  out_status;
  logic [47:0]           out_alloc_address;
  logic [15:0]           out_free_page_count;
  logic [15:0]           out_used_page_count;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [63:0]           pwdata;
  logic [63:0]           prdata;
  logic                  pready;

  contiguous_page_bitmap_allocator u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_action           (in_action),
    .in_pages_requested  (in_pages_requested),
    .in_address          (in_address),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_alloc_address   (out_alloc_address),
    .out_free_page_count (out_free_page_count),
    .out_used_page_count (out_used_page_count),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  // Shadow allocator state
  bit            page_used [POOL_MAX];
  int unsigned   shadow_free_cnt;
  bit [46:0]     base_reg;
  bit [15:0]     count_reg;
  alloc_result_t pending_results [$];
  page_run_t     live_runs [$];

  int unsigned   errors;
  int unsigned   out_stall_left;
  bit            calm_in;   // sender never idles while set
  bit            calm_out;  // receiver never stalls while set
  alloc_result_t seen_exp;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Random gap length for either channel; now and then a long hole.
  function automatic int unsigned pick_gap();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
  endfunction

  function automatic int unsigned pool_pages();
    return (count_reg > POOL_MAX) ? POOL_MAX : int'(count_reg);
  endfunction

  // Applies one request beat to the shadow state and returns the beat
  // the block must produce for it.
  function automatic alloc_result_t apply_request(bit [1:0] act, bit [15:0] n, bit [47:0] addr);
    alloc_result_t    r;
    int unsigned      total;
    int unsigned      run;
    int unsigned      p;
    int unsigned      first;
    longint unsigned  start;
    bit               found;
    page_run_t        rec;
    total = pool_pages();
    r.status = 1'b1;
    r.alloc_addr = '0;
    found = 1'b0;
    run = 0;
    case (act)
      ACT_ALLOC: begin
        if (n != 0 && n <= shadow_free_cnt) begin
          // first fit: lowest run that reaches n free pages
          for (p = 0; p < total; p++) begin
            run = page_used[p] ? 0 : run + 1;
            if (run == n) begin
              found = 1'b1;
              break;
            end
          end
          if (found) begin
            first = p + 1 - n;
            for (int q = first; q <= p; q++) page_used[q] = 1'b1;
            shadow_free_cnt -= n;
            r.alloc_addr = 48'({17'b0, base_reg} + longint'(first) * PAGE_BYTES);
            r.status = 1'b0;
            rec.addr = r.alloc_addr;
            rec.pages = n;
            live_runs.push_back(rec);
          end
        end
      end
      ACT_FREE: begin
        if (addr != 0 && n != 0 && {1'b0, addr} >= {2'b0, base_reg}) begin
          start = ({16'b0, addr} - {17'b0, base_reg}) >> PAGE_SHIFT;
          if (start < total && start + n <= total) begin
            for (longint unsigned q = start; q < start + n; q++) begin
              if (page_used[q]) begin
                page_used[q] = 1'b0;
                if (shadow_free_cnt < 'hFFFF) shadow_free_cnt++;
              end
            end
            r.status = 1'b0;
          end
        end
      end
      ACT_INIT: begin
        foreach (page_used[i]) page_used[i] = 1'b0;
        shadow_free_cnt = total;
        live_runs.delete();
        r.status = 1'b0;
      end
      default: ;
    endcase
    r.free_cnt = shadow_free_cnt[15:0];
    r.used_pages = (shadow_free_cnt > total) ? 16'd0 : 16'(total - shadow_free_cnt);
    return r;
  endfunction

  // Sends one request beat; valid is only lowered when a gap precedes it.
  task automatic send_item(input bit [1:0] act, input bit [15:0] n, input bit [47:0] addr);
    int unsigned gap;
    gap = (calm_in || $urandom_range(0, 1)) ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_action          <= act;
    in_pages_requested <= n;
    in_address         <= addr;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(apply_request(act, n, addr));
  endtask

  // Stop sending and wait for every predicted beat to come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Two-phase APB write; the register loads on the access edge.
  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] reg_addr, input logic [63:0] data);
    drain();
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= reg_addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_addr == REG_POOL_BASE) base_reg = data[46:0];
    else count_reg = data[15:0];
  endtask

  task automatic set_pool(input bit [46:0] base, input bit [15:0] count);
    cfg_write(REG_POOL_BASE, {17'b0, base});
    cfg_write(REG_PAGE_COUNT, {48'b0, count});
  endtask

  function automatic bit [46:0] rand_base();
    return 47'({$urandom, $urandom}) & 47'h7FFF_FFFF_F000;
  endfunction

  // Result monitor plus random out_ready stalls.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready      <= 1'b0;
      out_stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("result beat with nothing expected");
          errors++;
        end else begin
          seen_exp = pending_results.pop_front();
          if (out_status !== seen_exp.status) begin
            $error("status: expected %0d, got %0d", seen_exp.status, out_status);
            errors++;
          end
          if (out_alloc_address !== seen_exp.alloc_addr) begin
            $error("alloc_address: expected %h, got %h", seen_exp.alloc_addr, out_alloc_address);
            errors++;
          end
          if (out_free_page_count !== seen_exp.free_cnt) begin
            $error("free_page_count: expected %0d, got %0d",
                   seen_exp.free_cnt, out_free_page_count);
            errors++;
          end
          if (out_used_page_count !== seen_exp.used_pages) begin
            $error("used_page_count: expected %0d, got %0d",
                   seen_exp.used_pages, out_used_page_count);
            errors++;
          end
        end
      end
      if (out_stall_left > 0) begin
        out_stall_left--;
        out_ready <= 1'b0;
      end else if (!calm_out && $urandom_range(0, 99) < 20) begin
        out_stall_left = pick_gap() - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Right out of reset: empty pool, zero free count.
  task automatic test_after_reset();
    send_item(ACT_ALLOC, 16'd1, 48'd0);
    send_item(ACT_FREE, 16'd1, 48'h1000);
    send_item(ACT_INIT, 16'd0, 48'd0);
    send_item(ACT_ALLOC, 16'd1, 48'd0);
  endtask

  // Rejections, ignored frees, partial and repeated frees, fragmentation.
  task automatic test_directed_cases();
    bit [47:0] b;
    set_pool(47'h0000_1234_5000, 16'd64);
    b = 48'h0000_1234_5000;
    send_item(ACT_INIT, 16'd0, 48'd0);
    send_item(ACT_ALLOC, 16'd0, 48'd0);          // zero pages
    send_item(ACT_ALLOC, 16'd65, 48'd0);         // more than free
    send_item(ACT_ALLOC, 16'd1, 48'd0);
    send_item(ACT_ALLOC, 16'd63, 48'd0);         // fills the pool
    send_item(ACT_ALLOC, 16'd1, 48'd0);          // nothing left
    send_item(ACT_FREE, 16'd1, 48'd0);           // address zero
    send_item(ACT_FREE, 16'd0, b + 48'h1000);    // count zero
    send_item(ACT_FREE, 16'd1, b - 48'h1000);    // below base
    send_item(ACT_FREE, 16'd1, b + 48'h40000);   // start at pool end
    send_item(ACT_FREE, 16'd5, b + 48'h3C000);   // runs past pool end
    send_item(ACT_FREE, 16'd3, b + 48'h27FF);    // unaligned: pages 2..4
    send_item(ACT_FREE, 16'd3, b + 48'h2000);    // already free, still done
    send_item(ACT_FREE, 16'd1, b + 48'h1E000);   // page 30
    send_item(ACT_FREE, 16'd1, b + 48'h28000);   // page 40
    send_item(ACT_ALLOC, 16'd4, 48'd0);          // 5 free but no run of 4
    send_item(ACT_ALLOC, 16'd3, 48'd0);
    send_item(ACT_UNKNOWN, 16'hFFFF, 48'hFFFF_FFFF_FFFF);
    send_item(ACT_FREE, 16'd64, b);              // whole pool
  endtask

  // Extreme registers: top base, clamped size, size 0,
  // size shrunk below the free count without a new initialize.
  task automatic test_config_extremes();
    bit [47:0] b;
    set_pool(47'h7FFF_FFFF_FFFF, 16'hFFFF);
    b = 48'h7FFF_FFFF_FFFF;
    send_item(ACT_INIT, 16'd0, 48'd0);
    send_item(ACT_ALLOC, 16'h8000, 48'd0);
    send_item(ACT_ALLOC, 16'd1, 48'd0);
    send_item(ACT_FREE, 16'h8000, b);
    cfg_write(REG_PAGE_COUNT, 64'd16);
    send_item(ACT_ALLOC, 16'd2, 48'd0);
    send_item(ACT_FREE, 16'd20, b);
    set_pool(47'd0, 16'd0);
    send_item(ACT_INIT, 16'd0, 48'd0);
    send_item(ACT_FREE, 16'd1, 48'h1000);
  endtask

  // Random traffic on one pool: mostly allocs and frees of live runs.
  task automatic run_random_phase(input bit [46:0] base, input bit [15:0] count,
                                  input int unsigned items);
    int unsigned total;
    int unsigned r;
    int unsigned idx;
    int unsigned off;
    int unsigned n;
    page_run_t   rec;
    set_pool(base, count);
    total = pool_pages();
    send_item(ACT_INIT, 16'd0, 48'd0);
    for (int i = 0; i < items; i++) begin
      if (i % 40 == 0) begin
        calm_in  = ($urandom_range(0, 3) == 0);
        calm_out = ($urandom_range(0, 3) == 0);
      end
      if ($urandom_range(0, 99) < 3) drain();
      r = $urandom_range(0, 99);
      if (r < 45) begin
        r = $urandom_range(0, 99);
        if (r < 80) n = $urandom_range(1, 8);
        else if (r < 97) n = $urandom_range(1, total / 4 + 1);
        else n = $urandom_range(1, (total > 0) ? total : 1);
        send_item(ACT_ALLOC, 16'(n), 48'd0);
      end else if (r < 80 && live_runs.size() != 0) begin
        idx = $urandom_range(0, live_runs.size() - 1);
        rec = live_runs[idx];
        case ($urandom_range(0, 3))
          0: begin
            live_runs.delete(idx);
            send_item(ACT_FREE, 16'(rec.pages), rec.addr);
          end
          1: begin
            // part of the run from a random page on, at a possibly unaligned address
            off = $urandom_range(0, rec.pages - 1);
            live_runs.delete(idx);
            send_item(ACT_FREE, 16'($urandom_range(1, rec.pages - off)),
                      rec.addr + 48'(off) * 48'd4096 + 48'($urandom_range(0, 4095)));
          end
          2: send_item(ACT_FREE, 16'(rec.pages), rec.addr);  // may double free later
          default: begin
            live_runs.delete(idx);
            send_item(ACT_FREE, 16'(rec.pages + $urandom_range(0, 4)), rec.addr);
          end
        endcase
      end else if (r < 80) begin
        send_item(ACT_FREE, 16'($urandom_range(1, 8)),
                  {1'b0, base} + 48'($urandom_range(0, total + 2)) * 48'd4096);
      end else if (r < 85) begin
        send_item(ACT_INIT, 16'($urandom), 48'({$urandom, $urandom}));
      end else begin
        send_item(2'($urandom), 16'($urandom), 48'({$urandom, $urandom}));
      end
    end
    calm_in  = 1'b0;
    calm_out = 1'b0;
  endtask

  task automatic test_random_traffic();
    run_random_phase(rand_base(), 16'd64, 140);
    run_random_phase(47'd0, 16'd1000, 140);
    run_random_phase(rand_base(), 16'h8000, 120);
    run_random_phase(rand_base(), 16'($urandom_range(65, 400)), 140);
  endtask

  initial begin
    int unsigned waited;
    clk = 1'b0;
    rst_n              <= 1'b0;
    in_valid           <= 1'b0;
    in_action          <= ACT_ALLOC;
    in_pages_requested <= '0;
    in_address         <= '0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= REG_POOL_BASE;
    pwdata             <= '0;
    errors = 0;
    shadow_free_cnt = 0;
    base_reg = '0;
    count_reg = '0;
    calm_in = 1'b0;
    calm_out = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    // the block's post-reset map clear holds in_ready low; send_item waits it out

    test_after_reset();
    test_directed_cases();
    test_config_extremes();
    test_random_traffic();

    in_valid <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    if (pending_results.size() != 0) begin
      $error("%0d result beats never arrived", pending_results.size());
      errors++;
    end
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #20000000;
    $display("FAIL");
    $finish;
  end

endmodule
`default_nettype wire

>>> sim.f
sv/cpba_pkg.sv
sv/cpba_map_ram.sv
sv/cpba_word_scan.sv
sv/contiguous_page_bitmap_allocator.sv
dv/contiguous_page_bitmap_allocator_tb.sv
